[rtl/line_substring_matcher_top_assert.svh]
// Assertion macros for the line substring matcher.
`ifndef LINE_SUBSTRING_MATCHER_TOP_ASSERT_SVH
`define LINE_SUBSTRING_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line substring matcher: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line substring matcher: next-cycle check failed");

`endif

[rtl/lsm_pkg.sv]
// Shared types, constants and helpers for the line substring matcher.
`default_nettype none
package lsm_pkg;

  localparam int LEN_W     = 5;
  localparam int PAT_BYTES = 16;
  localparam int PAT_W     = 8 * PAT_BYTES;
  localparam int IDX_W     = 6;

  typedef enum logic [1:0] {
    CFG_LENGTH = 2'd0,
    CFG_LOW    = 2'd1,
    CFG_HIGH   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] pattern_length;
    logic [PAT_W-1:0] pattern;
  } cfg_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       highlight_end;
    logic       line_closed;
    logic       line_matched;
  } result_t;

  // Pattern byte at idx; bytes past the stored pattern read as zero.
  function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                          input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'd0;
    if (idx < IDX_W'(PAT_BYTES)) begin
      b = pat[8 * idx[3:0] +: 8];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

[rtl/line_substring_matcher_top.sv]
// Top level of the line substring matcher: input/result registers and config.
`default_nettype none
// Scans a text stream one byte per item for a fixed pattern of up to 16 bytes
// and echoes each byte with a flag on the last byte of every leftmost,
// non-overlapping occurrence; a line_end item reports whether the line held
// the pattern (an empty pattern matches every line). One item is accepted
// every cycle while in_stall is low; a result passes through the input
// register, then the result register, with the whole match evaluated
// combinationally between them. Stall on the result side backs up into
// in_stall through the same cycle. Config writes are always taken (cfg_ready
// is high) and apply to the next byte evaluated.
module line_substring_matcher_top #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  text_byte,
  input  wire logic        line_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       echo_byte,
  output logic             highlight_end,
  output logic             line_closed,
  output logic             line_matched,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import lsm_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;
  result_t    res;
  result_t    res_next;
  logic       advance;
  logic       accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LENGTH: cfg.pattern_length <= cfg_data[LEN_W-1:0];
        CFG_LOW:    cfg.pattern[63:0]   <= cfg_data;
        CFG_HIGH:   cfg.pattern[127:64] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= text_byte;
      s1_end  <= line_end;
    end
  end

  lsm_scan #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .item_byte(s1_byte),
    .item_end (s1_end),
    .cfg      (cfg),
    .result   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign echo_byte     = res.echo_byte;
  assign highlight_end = res.highlight_end;
  assign line_closed   = res.line_closed;
  assign line_matched  = res.line_matched;

endmodule
`default_nettype wire

[rtl/lsm_scan.sv]
// Per-line match state and combinational match/highlight evaluation.
`default_nettype none
`include "line_substring_matcher_top_assert.svh"
module lsm_scan #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       item_byte,
  input  wire logic             item_end,
  input  wire lsm_pkg::cfg_t    cfg,
  output lsm_pkg::result_t      result
);
  import lsm_pkg::*;

  localparam int HIST  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic [7:0]       recent [HIST];
  logic [CNT_W-1:0] bytes_cnt;
  logic [LEN_W-1:0] overlap;
  logic             line_hit;

  logic [LEN_W-1:0] len;
  logic             match;
  logic             hl;

  always_comb begin
    if (7'(cfg.pattern_length) > 7'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end else begin
      len = cfg.pattern_length;
    end
    match = (len != '0) && ((8'(bytes_cnt) + 8'd1) >= 8'(len)) &&
            (item_byte == pat_byte(cfg.pattern, IDX_W'(len) - IDX_W'(1)));
    for (int j = 0; j < HIST; j++) begin
      if ((j + 1) < int'(len) &&
          recent[j] != pat_byte(cfg.pattern, IDX_W'(int'(len) - 2 - j))) begin
        match = 1'b0;
      end
    end
    hl = match && (overlap == '0);
  end

  always_comb begin
    if (item_end) begin
      result.echo_byte     = 8'd0;
      result.highlight_end = 1'b0;
      result.line_closed   = 1'b1;
      result.line_matched  = line_hit || (len == '0);
    end else begin
      result.echo_byte     = item_byte;
      result.highlight_end = hl;
      result.line_closed   = 1'b0;
      result.line_matched  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_cnt <= '0;
      overlap   <= '0;
      line_hit  <= 1'b0;
    end else if (step) begin
      if (item_end) begin
        bytes_cnt <= '0;
        overlap   <= '0;
        line_hit  <= 1'b0;
      end else begin
        if (match) begin
          line_hit <= 1'b1;
        end
        if (hl) begin
          overlap <= len - LEN_W'(1);
        end else if (overlap != '0) begin
          overlap <= overlap - LEN_W'(1);
        end
        if (8'(bytes_cnt) < 8'(MAX_PATTERN)) begin
          bytes_cnt <= bytes_cnt + CNT_W'(1);
        end
      end
    end
  end

  // History of the line's last bytes, newest first.
  always_ff @(posedge clk) begin
    if (step && !item_end) begin
      recent[0] <= item_byte;
      for (int i = 1; i < HIST; i++) begin
        recent[i] <= recent[i-1];
      end
    end
  end

  `LSM_ASSERT_NEXT(a_line_end_clears, step && item_end,
    bytes_cnt == '0 && overlap == '0 && !line_hit)
  `LSM_ASSERT_NEXT(a_highlight_sets_hit, step && result.highlight_end, line_hit)
  `LSM_ASSERT_SAME(a_cnt_saturates, 1'b1, 8'(bytes_cnt) <= 8'(MAX_PATTERN))
  `LSM_ASSERT_SAME(a_highlight_unblocked, result.highlight_end,
    overlap == '0 && !item_end)

endmodule
`default_nettype wire

[tb/line_substring_matcher_top_tb.sv]
// Self-checking testbench for line_substring_matcher_top: pattern search over a byte stream.
module line_substring_matcher_top_tb;
  import lsm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;
  localparam int SEG_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  text_byte = 8'd0;
  logic        line_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  echo_byte;
  logic        highlight_end;
  logic        line_closed;
  logic        line_matched;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CFG_LENGTH;
  logic [63:0] cfg_data = 64'd0;

  // predictor state
  logic [4:0]   cur_len = 5'd0;
  logic [127:0] cur_pat = '0;
  logic [7:0]   history [15];
  int           line_fill = 0;
  int           block_left = 0;
  logic         seen_hit = 1'b0;
  result_t      expected_q [$];

  int errors = 0;
  int sent_items = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  line_substring_matcher_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .text_byte    (text_byte),
    .line_end     (line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .echo_byte    (echo_byte),
    .highlight_end(highlight_end),
    .line_closed  (line_closed),
    .line_matched (line_matched),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else
      out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic result_t scan_byte(input logic [7:0] ch, input logic le);
    result_t r;
    int      n;
    logic    hit;
    logic    mark;
    r = '0;
    n = (cur_len > 5'd16) ? 16 : int'(cur_len);
    if (le) begin
      r.line_closed  = 1'b1;
      r.line_matched = seen_hit || (n == 0);
      seen_hit   = 1'b0;
      line_fill  = 0;
      block_left = 0;
      return r;
    end
    hit  = 1'b0;
    mark = 1'b0;
    if (n > 0 && line_fill + 1 >= n) begin
      hit = (ch == cur_pat[8*(n-1) +: 8]);
      for (int k = 1; k < n; k++)
        if (history[k-1] != cur_pat[8*(n-1-k) +: 8]) hit = 1'b0;
    end
    if (hit) begin
      seen_hit = 1'b1;
      if (block_left == 0) mark = 1'b1;
    end
    if (mark) block_left = n - 1;
    else if (block_left > 0) block_left--;
    for (int k = 14; k > 0; k--) history[k] = history[k-1];
    history[0] = ch;
    if (line_fill < 16) line_fill++;
    r.echo_byte     = ch;
    r.highlight_end = mark;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] want, input logic [7:0] got);
    errors++;
    $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none got echo %0h hl %b closed %b matched %b",
                 $time, echo_byte, highlight_end, line_closed, line_matched);
      end else begin
        want = expected_q.pop_front();
        if (want.echo_byte !== echo_byte)
          note_mismatch("echo_byte", want.echo_byte, echo_byte);
        if (want.highlight_end !== highlight_end)
          note_mismatch("highlight_end", 8'(want.highlight_end), 8'(highlight_end));
        if (want.line_closed !== line_closed)
          note_mismatch("line_closed", 8'(want.line_closed), 8'(line_closed));
        if (want.line_matched !== line_matched)
          note_mismatch("line_matched", 8'(want.line_matched), 8'(line_matched));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic le);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    line_end  <= le;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(scan_byte(b, le));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LENGTH: cur_len = data[4:0];
      CFG_LOW:    cur_pat[63:0] = data;
      CFG_HIGH:   cur_pat[127:64] = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_pattern(input logic [4:0] len, input logic [63:0] lo,
                              input logic [63:0] hi);
    logic [63:0] d;
    d = {$urandom, $urandom};
    d[4:0] = len;
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
    write_reg(CFG_LENGTH, d);
    cfg_valid <= 1'b0;
  endtask

  // kind: 0 short, 1 length extremes, 2 uniform byte pattern, 3 any length
  task automatic pick_config(input int kind, input int variant,
                             output logic [7:0] a0, output logic [7:0] a1);
    logic [127:0] pat;
    logic [4:0]   len;
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    for (int j = 0; j < 16; j++) pat[8*j +: 8] = $urandom_range(1) ? a1 : a0;
    case (kind)
      0: len = 5'($urandom_range(1, 4));
      1: begin
        case (variant)
          0: len = 5'd0;
          1: len = 5'd16;
          2: len = 5'd31;
          default: len = 5'($urandom_range(17, 31));
        endcase
      end
      2: begin
        a0  = variant[0] ? 8'hFF : 8'h00;
        pat = {16{a0}};
        len = 5'($urandom_range(1, 16));
      end
      default: len = 5'($urandom_range(1, 16));
    endcase
    load_pattern(len, pat[63:0], pat[127:64]);
  endtask

  task automatic send_text_line(input logic [7:0] a0, input logic [7:0] a1);
    int n;
    int count;
    int k;
    int m;
    int pick;
    n = (cur_len > 5'd16) ? 16 : int'(cur_len);
    count = $urandom_range(2 * n + 8);
    k = 0;
    while (k < count) begin
      pick = $urandom_range(99);
      if (pick < 25 && n > 0) begin
        // whole pattern, or a near miss missing its last byte
        m = ($urandom_range(3) == 0) ? n - 1 : n;
        for (int j = 0; j < m; j++) push_byte(cur_pat[8*j +: 8], 1'b0);
        k += m + 1;
      end else begin
        if (pick < 85) push_byte($urandom_range(1) ? a1 : a0, 1'b0);
        else push_byte(8'($urandom), 1'b0);
        k++;
      end
    end
    push_byte(8'($urandom), 1'b1);
  endtask

  task automatic test_empty_pattern();
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h5A, 1'b1);
  endtask

  task automatic test_overlap();
    wait_drained();
    load_pattern(5'd2, 64'h6161, 64'd0);
    for (int j = 0; j < 4; j++) push_byte(8'h61, 1'b0);
    push_byte(8'h00, 1'b1);
  endtask

  // 16-byte match, then a new pattern mid-line while the overlap count runs
  task automatic test_long_pattern();
    logic [127:0] pat;
    for (int j = 0; j < 16; j++) pat[8*j +: 8] = 8'($urandom);
    pat[7:0]     = 8'h00;
    pat[127:120] = 8'hFF;
    wait_drained();
    load_pattern(5'd31, pat[63:0], pat[127:64]);
    for (int j = 0; j < 16; j++) push_byte(pat[8*j +: 8], 1'b0);
    wait_drained();
    load_pattern(5'd2, 64'h00FF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
  endtask

  task automatic test_backpressure();
    logic [7:0] a0;
    logic [7:0] a1;
    int start;
    wait_drained();
    pick_config(0, 0, a0, a1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    start = sent_items;
    while (sent_items - start < 60) send_text_line(a0, a1);
    wait_drained();
    while (sent_items - start < 100) send_text_line(a0, a1);
  endtask

  task automatic test_random_text();
    logic [7:0] a0;
    logic [7:0] a1;
    int start;
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        pick_config(seg, mode, a0, a1);
        start = sent_items;
        while (sent_items - start < SEG_ITEMS) send_text_line(a0, a1);
      end
    end
  endtask

  initial begin
    foreach (history[i]) history[i] = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_empty_pattern();
    test_overlap();
    test_long_pattern();
    test_backpressure();
    test_random_text();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_scan.sv
rtl/line_substring_matcher_top.sv
tb/line_substring_matcher_top_tb.sv
